>>> src/ghst_pkg.sv
// ----------------------------------------------------------------------------
// ghst_pkg: shared types and constants of the generational handle slot table
// Request and result payloads, operation and status codes, defaults.
// ----------------------------------------------------------------------------
package ghst_pkg;

    localparam int unsigned SLOTS_DEF    = 64;
    localparam int unsigned GEN_BITS_DEF = 16;
    localparam logic [31:0] AGE_LIMIT_RST = 32'd3;

    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_LOOKUP  = 3'd1;
    localparam logic [2:0] OP_DESTROY = 3'd2;
    localparam logic [2:0] OP_SETVAL  = 3'd3;
    localparam logic [2:0] OP_HOLD    = 3'd4;
    localparam logic [2:0] OP_TICK    = 3'd5;
    localparam logic [2:0] OP_GC      = 3'd6;
    localparam logic [2:0] OP_UNUSED  = 3'd7;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_TEXTURE = 2'd1;
    localparam logic [1:0] KIND_BUFFER  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    localparam int unsigned MAX_GC_RESULTS = 64;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  res_kind;
        logic [11:0] slot_index;
        logic [15:0] slot_generation;
        logic [63:0] gpu_value;
        logic        hold_flag;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  out_index;
        logic [15:0] out_generation;
        logic        was_deferred;
        logic [63:0] gpu_value_out;
        logic        last;
    } rsp_t;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        req_t req;
        logic idx_ok;
    } cmd_t;

endpackage

>>> src/ghst_front.sv
// ----------------------------------------------------------------------------
// ghst_front: request intake and classification
// Takes requests, checks the index range and queues them for the back part.
// ----------------------------------------------------------------------------
module ghst_front #(
    parameter int unsigned SLOTS = ghst_pkg::SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  ghst_pkg::req_t  req,
    input  logic            deq,
    output logic            q_valid,
    output ghst_pkg::cmd_t  q_head,
    output logic            busy
);

    localparam int unsigned QD = 2;

    ghst_pkg::cmd_t q_reg [QD];
    logic [1:0]     cnt_reg;
    logic           rd_reg;
    logic           wr_reg;
    logic           enq;

    // Busy while the queue is full; two requests may wait behind the one in work.
    assign busy    = (cnt_reg == 2'(QD));
    assign enq     = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head  = q_reg[rd_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_reg].req    <= req;
            q_reg[wr_reg].idx_ok <= ({20'd0, req.slot_index} < 32'(SLOTS));
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (enq)
                wr_reg <= ~wr_reg;
            if (deq)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(enq) - 2'(deq);
        end
    end

endmodule

>>> src/ghst_back.sv
// ----------------------------------------------------------------------------
// ghst_back: slot table execution
// Holds the slot memories and carries out each request with a read, then a
// write of one slot; gc walks every opened slot in turn.
// ----------------------------------------------------------------------------
module ghst_back #(
    parameter int unsigned SLOTS    = ghst_pkg::SLOTS_DEF,
    parameter int unsigned GEN_BITS = ghst_pkg::GEN_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     age_limit,
    input  logic            q_valid,
    input  ghst_pkg::cmd_t  q_head,
    output logic            deq,
    output logic            done,
    output ghst_pkg::rsp_t  rsp
);

    localparam int unsigned IW = $clog2(SLOTS);
    localparam int unsigned CW = IW + 1;

    typedef enum logic [1:0] { S_IDLE, S_EXEC, S_GCRD, S_GCWR } state_t;

    // Slot record; generation and the rest live in one memory.
    typedef struct packed {
        logic                alive;
        logic [GEN_BITS-1:0] gen;
        logic [1:0]          kind;
        logic                deferred;
        logic [63:0]         val;
        logic [31:0]         used;
        logic                held;
    } slot_t;

    slot_t         mem [SLOTS];
    logic [IW-1:0] stk [SLOTS];

    state_t         state_reg;
    ghst_pkg::cmd_t cmd_reg;
    slot_t          rd_reg;
    logic [IW-1:0]  top_reg;
    logic [CW-1:0]  free_cnt_reg;
    logic [CW-1:0]  slot_cnt_reg;
    logic [31:0]    frame_reg;
    logic [CW-1:0]  gc_i_reg;
    logic [6:0]     gc_n_reg;
    logic           done_reg;
    ghst_pkg::rsp_t rsp_reg;
    logic           pend_reg;
    ghst_pkg::rsp_t pend_data_reg;

    logic           mem_we;
    logic [IW-1:0]  mem_wa;
    slot_t          mem_wd;
    logic [IW-1:0]  mem_ra;
    logic           stk_we;
    logic [IW-1:0]  stk_wa;
    logic [IW-1:0]  stk_wd;
    logic [IW-1:0]  stk_ra;

    logic           gc_hit;
    logic           gc_end;
    logic [IW-1:0]  exec_idx;
    logic           h_ok;
    logic           fresh;
    ghst_pkg::rsp_t blank;

    always_comb
    begin
        blank = '0;
        blank.last = 1'b1;
    end

    assign deq  = (state_reg == S_IDLE) && q_valid;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Memory reads: slot record and free stack top, both registered. Create
    // fetches the record at the stack top while in S_GCRD.
    assign mem_ra = (state_reg == S_IDLE) ? q_head.req.slot_index[IW-1:0]
                  : (state_reg == S_GCRD && cmd_reg.req.req_type == ghst_pkg::OP_CREATE)
                  ? top_reg
                  : gc_i_reg[IW-1:0];
    assign stk_ra = free_cnt_reg[IW-1:0] - IW'(1);

    always_ff @(posedge clk)
    begin
        rd_reg  <= mem[mem_ra];
        top_reg <= stk[stk_ra];
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (stk_we)
            stk[stk_wa] <= stk_wd;
    end

    // Handle check and gc qualification on the read record.
    assign fresh    = (free_cnt_reg == CW'(0));
    assign exec_idx = cmd_reg.req.slot_index[IW-1:0];
    assign h_ok     = cmd_reg.idx_ok && ({1'b0, exec_idx} < slot_cnt_reg) && rd_reg.alive
                      && (rd_reg.gen == cmd_reg.req.slot_generation[GEN_BITS-1:0]);
    assign gc_hit   = rd_reg.alive && !rd_reg.held
                      && ((frame_reg - rd_reg.used) > age_limit);
    assign gc_end   = (gc_i_reg + CW'(1) >= slot_cnt_reg) || (gc_hit && gc_n_reg == 7'd63);

    // Write side of the memories for the execute, create write and gc steps.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = exec_idx;
        mem_wd = rd_reg;
        stk_we = 1'b0;
        stk_wa = free_cnt_reg[IW-1:0];
        stk_wd = exec_idx;
        if (state_reg == S_EXEC)
        begin
            unique case (cmd_reg.req.req_type)
                ghst_pkg::OP_CREATE:
                begin
                    // Create writes its slot later, in S_GCWR.
                    mem_we = 1'b0;
                end
                ghst_pkg::OP_LOOKUP:
                begin
                    mem_we          = h_ok && (rd_reg.kind == cmd_reg.req.res_kind);
                    mem_wd.deferred = 1'b0;
                    mem_wd.used     = frame_reg;
                end
                ghst_pkg::OP_DESTROY:
                begin
                    mem_we       = h_ok;
                    mem_wd.alive = 1'b0;
                    mem_wd.kind  = ghst_pkg::KIND_NONE;
                    mem_wd.held  = 1'b0;
                    stk_we       = h_ok && (free_cnt_reg < CW'(SLOTS));
                end
                ghst_pkg::OP_SETVAL:
                begin
                    mem_we          = h_ok;
                    mem_wd.val      = cmd_reg.req.gpu_value;
                    mem_wd.deferred = 1'b0;
                end
                ghst_pkg::OP_HOLD:
                begin
                    mem_we      = h_ok;
                    mem_wd.held = cmd_reg.req.hold_flag;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_GCWR && cmd_reg.req.req_type == ghst_pkg::OP_CREATE)
        begin
            // Create's second step writes the chosen slot.
            mem_we         = 1'b1;
            mem_wa         = fresh ? slot_cnt_reg[IW-1:0] : top_reg;
            mem_wd.alive   = 1'b1;
            mem_wd.gen     = fresh ? '0 : rd_reg.gen + GEN_BITS'(1);
            mem_wd.kind    = cmd_reg.req.res_kind;
            mem_wd.deferred = 1'b1;
            mem_wd.val     = 64'd0;
            mem_wd.used    = fresh ? 32'd0 : rd_reg.used;
            mem_wd.held    = 1'b0;
        end
        else if (state_reg == S_GCRD && cmd_reg.req.req_type == ghst_pkg::OP_GC)
        begin
            mem_we       = gc_hit;
            mem_wa       = gc_i_reg[IW-1:0];
            mem_wd.alive = 1'b0;
            mem_wd.kind  = ghst_pkg::KIND_NONE;
            mem_wd.held  = 1'b0;
            stk_we       = gc_hit && (free_cnt_reg < CW'(SLOTS));
            stk_wd       = gc_i_reg[IW-1:0];
        end
    end

    // Sequencer: fetch, execute, and the gc walk.  Create reads the slot at
    // the stack top in S_GCRD before writing it, or a fresh slot if the stack is empty, in S_GCWR.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_cnt_reg  <= '0;
            slot_cnt_reg  <= '0;
            frame_reg     <= 32'd0;
            gc_i_reg      <= '0;
            gc_n_reg      <= 7'd0;
            done_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            cmd_reg       <= '0;
            rsp_reg       <= '0;
            pend_data_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    gc_i_reg <= '0;
                    gc_n_reg <= 7'd0;
                    if (q_valid)
                    begin
                        cmd_reg   <= q_head;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    rsp_reg   <= blank;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    case (cmd_reg.req.req_type) inside
                        ghst_pkg::OP_CREATE:
                        begin
                            done_reg <= 1'b0;
                            if (fresh && slot_cnt_reg >= CW'(SLOTS))
                            begin
                                rsp_reg.status <= ghst_pkg::ST_FULL;
                                done_reg       <= 1'b1;
                            end
                            else
                                state_reg <= S_GCRD;
                        end
                        ghst_pkg::OP_LOOKUP:
                        begin
                            if (h_ok && rd_reg.kind == cmd_reg.req.res_kind)
                            begin
                                rsp_reg.out_index      <= 6'(exec_idx);
                                rsp_reg.out_generation <= 16'(rd_reg.gen);
                                rsp_reg.was_deferred   <= rd_reg.deferred;
                                rsp_reg.gpu_value_out  <= rd_reg.val;
                            end
                            else
                                rsp_reg.status <= ghst_pkg::ST_INVALID;
                        end
                        ghst_pkg::OP_DESTROY, ghst_pkg::OP_SETVAL, ghst_pkg::OP_HOLD:
                        begin
                            if (!h_ok)
                                rsp_reg.status <= ghst_pkg::ST_INVALID;
                            else if (cmd_reg.req.req_type == ghst_pkg::OP_DESTROY
                                     && free_cnt_reg < CW'(SLOTS))
                                free_cnt_reg <= free_cnt_reg + CW'(1);
                        end
                        ghst_pkg::OP_TICK:
                            frame_reg <= frame_reg + 32'd1;
                        ghst_pkg::OP_GC:
                        begin
                            done_reg <= 1'b0;
                            if (slot_cnt_reg == CW'(0))
                            begin
                                rsp_reg.status <= ghst_pkg::ST_NONE;
                                done_reg       <= 1'b1;
                            end
                            else
                                state_reg <= S_GCRD;
                        end
                        default:
                            rsp_reg.status <= ghst_pkg::ST_INVALID;
                    endcase
                end
                S_GCRD:
                begin
                    if (cmd_reg.req.req_type == ghst_pkg::OP_CREATE)
                    begin
                        // Stack top is valid in top_reg; fetch its record.
                        state_reg <= S_GCWR;
                    end
                    else
                    begin
                        // One slot of the gc walk; results lag by one so the
                        // final one can carry last.
                        if (gc_hit)
                        begin
                            if (free_cnt_reg < CW'(SLOTS))
                                free_cnt_reg <= free_cnt_reg + CW'(1);
                            if (pend_reg)
                            begin
                                rsp_reg  <= pend_data_reg;
                                done_reg <= 1'b1;
                            end
                            pend_reg                     <= 1'b1;
                            pend_data_reg                <= '0;
                            pend_data_reg.out_index      <= 6'(gc_i_reg[IW-1:0]);
                            pend_data_reg.out_generation <= 16'(rd_reg.gen);
                            gc_n_reg <= gc_n_reg + 7'd1;
                        end
                        gc_i_reg  <= gc_i_reg + CW'(1);
                        state_reg <= S_GCWR;
                        if (gc_end)
                            gc_i_reg <= slot_cnt_reg;
                    end
                end
                S_GCWR:
                begin
                    if (cmd_reg.req.req_type == ghst_pkg::OP_CREATE)
                    begin
                        rsp_reg        <= blank;
                        rsp_reg.out_index <= 6'(fresh ? slot_cnt_reg[IW-1:0] : top_reg);
                        rsp_reg.out_generation <=
                            16'(fresh ? '0 : rd_reg.gen + GEN_BITS'(1));
                        done_reg       <= 1'b1;
                        if (fresh)
                            slot_cnt_reg <= slot_cnt_reg + CW'(1);
                        else
                            free_cnt_reg <= free_cnt_reg - CW'(1);
                        state_reg <= S_IDLE;
                    end
                    else if (gc_i_reg >= slot_cnt_reg)
                    begin
                        // Walk over: flush the held result with last set, or report none collected.
                        done_reg <= 1'b1;
                        rsp_reg  <= blank;
                        if (pend_reg)
                        begin
                            rsp_reg      <= pend_data_reg;
                            rsp_reg.last <= 1'b1;
                        end
                        else
                            rsp_reg.status <= ghst_pkg::ST_NONE;
                        pend_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_GCRD;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> src/generational_handle_slot_table.sv
// ----------------------------------------------------------------------------
// generational_handle_slot_table: top level of the handle slot table
// Front intake queue, back execution unit and the gc age limit register.
// ----------------------------------------------------------------------------
// Table requests pass the fetch and execute states; create adds a stack-top
// read and a slot write. The back part takes the next request only when idle.
// Gc visits every opened slot through a read and a write state and gives one
// result per freed slot. Two requests may queue while one is in work.
// Reset clears the counters and the frame counter and sets the age limit to 3;
// slot memories need no clearing. Results cannot be stalled.
module generational_handle_slot_table #(
    parameter int unsigned SLOTS    = ghst_pkg::SLOTS_DEF,
    parameter int unsigned GEN_BITS = ghst_pkg::GEN_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  ghst_pkg::req_t  req,
    output logic            busy,
    output logic            strobe,
    output ghst_pkg::rsp_t  result,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_data
);

    logic           q_valid;
    ghst_pkg::cmd_t q_head;
    logic           deq;
    logic [31:0]    age_limit_reg;

    // Age limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            age_limit_reg <= ghst_pkg::AGE_LIMIT_RST;
        else if (cfg_we)
            age_limit_reg <= cfg_data;
    end

    ghst_front #(.SLOTS(SLOTS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .deq     (deq),
        .q_valid (q_valid),
        .q_head  (q_head),
        .busy    (busy)
    );

    ghst_back #(.SLOTS(SLOTS), .GEN_BITS(GEN_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .age_limit (age_limit_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .deq       (deq),
        .done      (strobe),
        .rsp       (result)
    );

    // A failed or full result carries no handle.
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.status == ghst_pkg::ST_INVALID || result.status == ghst_pkg::ST_FULL)
        |-> (result.out_index == 6'd0 && result.last))
        else $error("error result carries payload");

    // Only successful lookups return a deferred mark.
    a_def_ok: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.was_deferred |-> result.status == ghst_pkg::ST_OK)
        else $error("deferred mark on failed result");

    // Nothing-collected result is always the last.
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status == ghst_pkg::ST_NONE |-> result.last)
        else $error("nothing collected without last");

endmodule
